/* src/hbs_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Height map sampler package
// Shared constants, configuration and job types, and state encodings.
// ---------------------------------------------------------------------------
package hbs_pkg;

   localparam int MaxWidth    = 64;
   localparam int MaxLength   = 64;
   localparam int CellBits    = 16;

   localparam int IdxBitsMax  = 10;
   localparam int AddrBitsMax = 20;
   localparam int CellBitsMax = 24;
   localparam int SumBits     = 28;

   localparam logic [16:0] HalfWeight = 17'd32768;
   localparam logic [16:0] FullWeight = 17'd65536;

   typedef enum logic [3:0] {
      CSR_ORIGIN_X      = 4'd0,
      CSR_ORIGIN_Z      = 4'd1,
      CSR_SCALE_X       = 4'd2,
      CSR_SCALE_Z       = 4'd3,
      CSR_HEIGHT_SCALE  = 4'd4,
      CSR_HEIGHT_OFFSET = 4'd5,
      CSR_MAP_WIDTH     = 4'd6,
      CSR_MAP_LENGTH    = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0] origin_x;
      logic [31:0] origin_z;
      logic [31:0] scale_x;
      logic [31:0] scale_z;
      logic [31:0] height_scale;
      logic [31:0] height_offset;
      logic [6:0]  map_width;
      logic [6:0]  map_length;
   } cfg_type;

   typedef struct packed {
      logic [IdxBitsMax-1:0] lo;
      logic [IdxBitsMax-1:0] hi;
      logic [16:0]           w;
   } axis_type;

   typedef struct packed {
      logic                          is_write;
      logic                          wr_ok;
      logic [CellBitsMax-1:0]        wdata;
      logic [3:0][AddrBitsMax-1:0]   addr;
      logic [16:0]                   wx;
      logic [16:0]                   wz;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_WR_RD,
      B_WR_UPD,
      B_Q_RD,
      B_Q_MUL1,
      B_Q_MUL2,
      B_SCALE,
      B_FIN,
      B_OUT
   } back_state_type;

endpackage
`default_nettype wire

/* src/hbs_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Height map sampler channels
// Request, response and register write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface hbs_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [5:0]         cell_x;
   logic [5:0]         cell_z;
   logic [15:0]        cell_height;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_z;
   modport source (output valid, mode, cell_x, cell_z, cell_height, pos_x, pos_z,
                   input ready);
   modport sink (input valid, mode, cell_x, cell_z, cell_height, pos_x, pos_z,
                 output ready);
endinterface

interface hbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] height;
   logic [27:0]        height_sum;
   modport source (output valid, height, height_sum, input ready);
   modport sink (input valid, height, height_sum, output ready);
endinterface

interface hbs_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/hbs_csr.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Height map sampler registers
// Holds the configuration registers written through the register channel.
// ---------------------------------------------------------------------------
module hbs_csr (
   input  logic            clock,
   input  logic            reset,
   hbs_csr_if.sink         csr,
   output hbs_pkg::cfg_type cfg
);

   hbs_pkg::cfg_type cfg_ff;
   hbs_pkg::cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (hbs_pkg::csr_index_type'(csr.index))
            hbs_pkg::CSR_ORIGIN_X:      cfg_in.origin_x      = csr.data;
            hbs_pkg::CSR_ORIGIN_Z:      cfg_in.origin_z      = csr.data;
            hbs_pkg::CSR_SCALE_X:       cfg_in.scale_x       = csr.data;
            hbs_pkg::CSR_SCALE_Z:       cfg_in.scale_z       = csr.data;
            hbs_pkg::CSR_HEIGHT_SCALE:  cfg_in.height_scale  = csr.data;
            hbs_pkg::CSR_HEIGHT_OFFSET: cfg_in.height_offset = csr.data;
            hbs_pkg::CSR_MAP_WIDTH:     cfg_in.map_width     = csr.data[6:0];
            hbs_pkg::CSR_MAP_LENGTH:    cfg_in.map_length    = csr.data[6:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x      <= 32'd0;
         cfg_ff.origin_z      <= 32'd0;
         cfg_ff.scale_x       <= 32'd65536;
         cfg_ff.scale_z       <= 32'd65536;
         cfg_ff.height_scale  <= 32'd65536;
         cfg_ff.height_offset <= 32'd0;
         cfg_ff.map_width     <= 7'd64;
         cfg_ff.map_length    <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* src/hbs_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Height map sampler front end
// Accepts request beats, maps positions to grid cells and weights, and
// pushes one job per beat into the queue.
// ---------------------------------------------------------------------------
module hbs_front #(
   parameter int MAX_WIDTH  = hbs_pkg::MaxWidth,
   parameter int MAX_LENGTH = hbs_pkg::MaxLength,
   parameter int CELL_BITS  = hbs_pkg::CellBits
) (
   input  logic                      clock,
   input  logic                      reset,
   hbs_req_if.sink                   req,
   input  hbs_pkg::cfg_type          cfg,
   input  hbs_pkg::back_status_type  bstat,
   input  hbs_pkg::queue_status_type qstat,
   output logic                      push,
   output hbs_pkg::job_type          job
);

   hbs_pkg::front_state_type state_ff, state_in;

   logic        mode_ff, mode_in;
   logic [5:0]  cx_ff, cx_in, cz_ff, cz_in;
   logic [15:0] ch_ff, ch_in;
   logic [32:0] dx_ff, dx_in, dz_ff, dz_in;
   logic [47:0] qx_ff, qx_in, qz_ff, qz_in;
   logic        px_ff, px_in, pz_ff, pz_in;
   logic [63:0] prod_x, prod_z;
   logic        accept;
   hbs_pkg::axis_type ax, az;
   logic [hbs_pkg::CellBitsMax-1:0] wmask;

   function automatic logic [31:0] clamp_size(input logic [6:0] v, input int mx);
      logic [31:0] r;
      r = 32'(v);
      if (v == 7'd0) begin
         r = 32'd1;
      end else if (32'(v) > 32'(mx)) begin
         r = 32'(mx);
      end
      return r;
   endfunction

   function automatic hbs_pkg::axis_type axis_calc(input logic pos, input logic [47:0] q,
                                                   input logic [31:0] n);
      hbs_pkg::axis_type a;
      logic [31:0] ip;
      logic [15:0] frac;
      ip   = q[47:16];
      frac = q[15:0];
      a.lo = '0;
      a.hi = '0;
      a.w  = hbs_pkg::HalfWeight;
      if (pos) begin
         if (ip >= n - 32'd1) begin
            a.lo = hbs_pkg::IdxBitsMax'(n - 32'd1);
            a.hi = hbs_pkg::IdxBitsMax'(n - 32'd1);
         end else begin
            a.lo = hbs_pkg::IdxBitsMax'(ip);
            if (frac == 16'd0) begin
               a.hi = a.lo;
            end else begin
               a.hi = a.lo + hbs_pkg::IdxBitsMax'(1);
               a.w  = hbs_pkg::FullWeight - {1'b0, frac};
            end
         end
      end
      return a;
   endfunction

   function automatic logic [hbs_pkg::AddrBitsMax-1:0] addr_of(
         input logic [hbs_pkg::IdxBitsMax-1:0] x, input logic [hbs_pkg::IdxBitsMax-1:0] z);
      return hbs_pkg::AddrBitsMax'(32'(x) * 32'(MAX_LENGTH) + 32'(z));
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hbs_pkg::F_IDLE: if (accept) state_in = hbs_pkg::F_MUL;
         hbs_pkg::F_MUL:  state_in = hbs_pkg::F_PUSH;
         hbs_pkg::F_PUSH: if (!qstat.full) state_in = hbs_pkg::F_IDLE;
         default:         state_in = hbs_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req.ready = (state_ff == hbs_pkg::F_IDLE) && !bstat.clearing;
      push      = (state_ff == hbs_pkg::F_PUSH) && !qstat.full;
   end

   assign accept = req.valid && req.ready;
   assign prod_x = 64'(dx_ff[31:0]) * 64'(cfg.scale_x);
   assign prod_z = 64'(dz_ff[31:0]) * 64'(cfg.scale_z);

   always_comb begin
      mode_in = mode_ff;
      cx_in   = cx_ff;
      cz_in   = cz_ff;
      ch_in   = ch_ff;
      dx_in   = dx_ff;
      dz_in   = dz_ff;
      qx_in   = qx_ff;
      qz_in   = qz_ff;
      px_in   = px_ff;
      pz_in   = pz_ff;
      if (accept) begin
         mode_in = req.mode;
         cx_in   = req.cell_x;
         cz_in   = req.cell_z;
         ch_in   = req.cell_height;
         dx_in   = {req.pos_x[31], req.pos_x} - {cfg.origin_x[31], cfg.origin_x};
         dz_in   = {req.pos_z[31], req.pos_z} - {cfg.origin_z[31], cfg.origin_z};
      end
      if (state_ff == hbs_pkg::F_MUL) begin
         qx_in = prod_x[63:16];
         qz_in = prod_z[63:16];
         px_in = !dx_ff[32] && (dx_ff[31:0] != 32'd0);
         pz_in = !dz_ff[32] && (dz_ff[31:0] != 32'd0);
      end
   end

   assign wmask = (hbs_pkg::CellBitsMax'(1) << CELL_BITS) - hbs_pkg::CellBitsMax'(1);

   always_comb begin
      ax = axis_calc(px_ff, qx_ff, clamp_size(cfg.map_width, MAX_WIDTH));
      az = axis_calc(pz_ff, qz_ff, clamp_size(cfg.map_length, MAX_LENGTH));
      job.is_write = !mode_ff;
      job.wr_ok    = (32'(cx_ff) < 32'(MAX_WIDTH)) && (32'(cz_ff) < 32'(MAX_LENGTH));
      job.wdata    = hbs_pkg::CellBitsMax'(ch_ff) & wmask;
      job.wx       = ax.w;
      job.wz       = az.w;
      if (mode_ff) begin
         job.addr[0] = addr_of(ax.lo, az.lo);
         job.addr[1] = addr_of(ax.hi, az.lo);
         job.addr[2] = addr_of(ax.lo, az.hi);
         job.addr[3] = addr_of(ax.hi, az.hi);
      end else begin
         job.addr[0] = addr_of(hbs_pkg::IdxBitsMax'(cx_ff), hbs_pkg::IdxBitsMax'(cz_ff));
         job.addr[1] = '0;
         job.addr[2] = '0;
         job.addr[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbs_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      cx_ff   <= cx_in;
      cz_ff   <= cz_in;
      ch_ff   <= ch_in;
      dx_ff   <= dx_in;
      dz_ff   <= dz_in;
      qx_ff   <= qx_in;
      qz_ff   <= qz_in;
      px_ff   <= px_in;
      pz_ff   <= pz_in;
   end

endmodule
`default_nettype wire

/* src/hbs_queue.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Height map sampler job queue
// Two-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module hbs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  hbs_pkg::job_type          push_job,
   input  logic                      pop,
   output hbs_pkg::job_type          head_job,
   output hbs_pkg::queue_status_type status
);

   hbs_pkg::job_type slot_ff [2];
   hbs_pkg::job_type slot_in [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head_job     = slot_ff[rp_ff];
   assign status.full  = (cnt_ff == 2'd2);
   assign status.empty = (cnt_ff == 2'd0);

   always_comb begin
      slot_in = slot_ff;
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         slot_in[wp_ff] = push_job;
         wp_in          = !wp_ff;
      end
      if (pop) begin
         rp_in = !rp_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
`default_nettype wire

/* src/hbs_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Height map sampler back end
// Owns the cell memory and running sum, performs writes and the four-cell
// blend, scales the result and drives the response register.
// ---------------------------------------------------------------------------
module hbs_back #(
   parameter int MAX_WIDTH  = hbs_pkg::MaxWidth,
   parameter int MAX_LENGTH = hbs_pkg::MaxLength,
   parameter int CELL_BITS  = hbs_pkg::CellBits
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hbs_pkg::cfg_type          cfg,
   input  hbs_pkg::queue_status_type qstat,
   input  hbs_pkg::job_type          head_job,
   output logic                      pop,
   output hbs_pkg::back_status_type  status,
   hbs_rsp_if.source                 rsp
);

   localparam int Depth = MAX_WIDTH * MAX_LENGTH;
   localparam int AW    = $clog2(Depth);
   localparam int AccW  = 32 + CELL_BITS;
   localparam int TW    = 17 + CELL_BITS;

   hbs_pkg::back_state_type state_ff, state_in;

   logic [CELL_BITS-1:0] mem [Depth];
   logic [CELL_BITS-1:0] rdata_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [CELL_BITS-1:0] mem_wdata;

   logic [AW-1:0]               clr_ff, clr_in;
   hbs_pkg::job_type            cur_ff, cur_in;
   logic [1:0]                  k_ff, k_in;
   logic [TW-1:0]               t_ff, t_in;
   logic [AccW-1:0]             acc_ff, acc_in;
   logic [63:0]                 prod_ff, prod_in;
   logic [31:0]                 h_ff, h_in;
   logic [hbs_pkg::SumBits-1:0] sum_ff, sum_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_h_ff, rsp_h_in;
   logic [hbs_pkg::SumBits-1:0] rsp_sum_ff, rsp_sum_in;

   logic [16:0]          wxs, wzs;
   logic [TW-1:0]        t_prod;
   logic [TW+16:0]       wt_prod;
   logic signed [33:0]   hwide;
   logic                 out_free, load;
   logic [CELL_BITS-1:0] wval;

   assign status.clearing = (state_ff == hbs_pkg::B_CLEAR);
   assign out_free        = !rsp_valid_ff || rsp.ready;
   assign load            = (state_ff == hbs_pkg::B_OUT) && out_free;
   assign pop             = (state_ff == hbs_pkg::B_IDLE) && !qstat.empty;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.height     = rsp_h_ff;
   assign rsp.height_sum = rsp_sum_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hbs_pkg::B_CLEAR:  if (clr_ff == AW'(Depth - 1)) state_in = hbs_pkg::B_IDLE;
         hbs_pkg::B_IDLE: begin
            if (pop) begin
               state_in = head_job.is_write ? hbs_pkg::B_WR_RD : hbs_pkg::B_Q_RD;
            end
         end
         hbs_pkg::B_WR_RD:  state_in = hbs_pkg::B_WR_UPD;
         hbs_pkg::B_WR_UPD: state_in = hbs_pkg::B_OUT;
         hbs_pkg::B_Q_RD:   state_in = hbs_pkg::B_Q_MUL1;
         hbs_pkg::B_Q_MUL1: state_in = hbs_pkg::B_Q_MUL2;
         hbs_pkg::B_Q_MUL2: state_in = (k_ff == 2'd3) ? hbs_pkg::B_SCALE : hbs_pkg::B_Q_RD;
         hbs_pkg::B_SCALE:  state_in = hbs_pkg::B_FIN;
         hbs_pkg::B_FIN:    state_in = hbs_pkg::B_OUT;
         hbs_pkg::B_OUT:    if (out_free) state_in = hbs_pkg::B_IDLE;
         default:           state_in = hbs_pkg::B_IDLE;
      endcase
   end

   assign wxs     = k_ff[0] ? hbs_pkg::FullWeight - cur_ff.wx : cur_ff.wx;
   assign wzs     = k_ff[1] ? hbs_pkg::FullWeight - cur_ff.wz : cur_ff.wz;
   assign t_prod  = TW'(wxs) * TW'(rdata_ff);
   assign wt_prod = (TW + 17)'(wzs) * (TW + 17)'(t_ff);
   assign hwide   = signed'({2'b00, prod_ff[63:32]})
                  + signed'({{2{cfg.height_offset[31]}}, cfg.height_offset});
   assign wval    = cur_ff.wdata[CELL_BITS-1:0];

   always_comb begin
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      h_in         = h_ff;
      sum_in       = sum_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff.addr[0][AW-1:0];
      mem_wdata    = wval;
      mem_raddr    = cur_ff.addr[k_ff][AW-1:0];
      case (state_ff)
         hbs_pkg::B_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
         end
         hbs_pkg::B_IDLE: begin
            if (pop) begin
               cur_in = head_job;
               k_in   = 2'd0;
               acc_in = '0;
            end
         end
         hbs_pkg::B_WR_UPD: begin
            h_in = 32'd0;
            if (cur_ff.wr_ok) begin
               mem_we = 1'b1;
               sum_in = sum_ff - hbs_pkg::SumBits'(rdata_ff) + hbs_pkg::SumBits'(wval);
            end
         end
         hbs_pkg::B_Q_MUL1: t_in = t_prod;
         hbs_pkg::B_Q_MUL2: begin
            acc_in = acc_ff + AccW'(wt_prod);
            k_in   = k_ff + 2'd1;
         end
         hbs_pkg::B_SCALE: prod_in = 64'(acc_ff[AccW-1:CELL_BITS]) * 64'(cfg.height_scale);
         hbs_pkg::B_FIN: begin
            if (hwide[33:31] == 3'b000 || hwide[33:31] == 3'b111) begin
               h_in = hwide[31:0];
            end else if (hwide[33]) begin
               h_in = 32'h8000_0000;
            end else begin
               h_in = 32'h7FFF_FFFF;
            end
         end
         hbs_pkg::B_OUT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_h_in     = h_ff;
               rsp_sum_in   = sum_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbs_pkg::B_CLEAR;
         clr_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      k_ff       <= k_in;
      t_ff       <= t_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      h_ff       <= h_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_sum_ff <= rsp_sum_in;
   end

endmodule
`default_nettype wire

/* src/heightmap_bilinear_sampler_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Height map bilinear sampler
// Stores a grid of cell heights and answers interpolated height queries.
//
//   Channel  Direction  Beat carries
//   req_if   in         mode, cell_x, cell_z, cell_height, pos_x, pos_z
//   rsp_if   out        height, height_sum
//   csr_if   in         index, data (register write)
//
// After reset the cell memory is swept to zero, one cell a cycle, over all
// MAX_WIDTH * MAX_LENGTH cells; no request beat is taken meanwhile.
// In the back end a query reads and blends its four cells one after another, owing to
// the single memory read port and the shared blend multipliers; the front end
// works on the next beat in parallel, through a two-entry job queue.
// A response register lets the back end continue while a result waits.
// ---------------------------------------------------------------------------
module heightmap_bilinear_sampler_unit #(
   parameter int MAX_WIDTH  = hbs_pkg::MaxWidth,
   parameter int MAX_LENGTH = hbs_pkg::MaxLength,
   parameter int CELL_BITS  = hbs_pkg::CellBits
) (
   input  logic      clock,
   input  logic      reset,
   hbs_req_if.sink   req_if,
   hbs_rsp_if.source rsp_if,
   hbs_csr_if.sink   csr_if
);

   hbs_pkg::cfg_type          cfg;
   hbs_pkg::job_type          push_job, head_job;
   hbs_pkg::queue_status_type qstat;
   hbs_pkg::back_status_type  bstat;
   logic                      push, pop;

   hbs_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .cfg   (cfg)
   );

   hbs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_LENGTH (MAX_LENGTH),
      .CELL_BITS  (CELL_BITS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .cfg   (cfg),
      .bstat (bstat),
      .qstat (qstat),
      .push  (push),
      .job   (push_job)
   );

   hbs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (qstat)
   );

   hbs_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_LENGTH (MAX_LENGTH),
      .CELL_BITS  (CELL_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .qstat    (qstat),
      .head_job (head_job),
      .pop      (pop),
      .status   (bstat),
      .rsp      (rsp_if)
   );

endmodule
`default_nettype wire

/* tb/tb_heightmap_bilinear_sampler_unit.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Height map sampler testbench
// Drives cell writes and height queries through several register settings,
// predicts every response beat with its own bilinear model and compares
// height and height sum field by field, under random idling on both sides.
// ---------------------------------------------------------------------------
module tb_heightmap_bilinear_sampler_unit;

   typedef struct {
      bit        mode;
      bit [5:0]  cell_x;
      bit [5:0]  cell_z;
      bit [15:0] cell_height;
      bit [31:0] pos_x;
      bit [31:0] pos_z;
   } sample_beat_type;

   typedef struct {
      bit [31:0] height;
      bit [27:0] height_sum;
   } height_result_type;

   localparam int Settle    = 40;
   localparam int CycleCap  = 600000;
   localparam bit ModeWrite = 1'b0;
   localparam bit ModeQuery = 1'b1;

   logic clock;
   logic reset;

   hbs_req_if req_if ();
   hbs_rsp_if rsp_if ();
   hbs_csr_if csr_if ();

   heightmap_bilinear_sampler_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   bit [15:0]         grid [hbs_pkg::MaxWidth][hbs_pkg::MaxLength];
   bit [27:0]         grid_sum;
   hbs_pkg::cfg_type  cfg;
   sample_beat_type   pending_beats [$];
   height_result_type expected_heights [$];
   sample_beat_type   cur_beat;
   int                errors;
   int                req_gap;
   int                rsp_gap;
   int                hold_cnt;
   bit                hold_done;
   bit                calm;
   int                rsp_seen;
   int                n_writes;
   int                n_queries;
   int                n_settings;
   int                cycles;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int clamp_size(bit [6:0] v, int max);
      if (v == 0) return 1;
      return (v > max) ? max : int'(v);
   endfunction

   function automatic void map_axis(input bit [31:0] pos, input bit [31:0] org,
                                    input bit [31:0] scl, input int n,
                                    output int lo, output int hi,
                                    output longint unsigned w);
      longint            d;
      longint unsigned   q;
      longint unsigned   ip;
      longint unsigned   frac;
      d = longint'($signed(pos)) - longint'($signed(org));
      lo = 0;
      hi = 0;
      w = 32768;
      if (d <= 0) return;
      q = ($unsigned(d) * 64'(scl)) >> 16;
      ip = q >> 16;
      frac = q & 64'hFFFF;
      if (ip >= 64'(n - 1)) begin
         lo = n - 1;
         hi = n - 1;
         return;
      end
      lo = int'(ip);
      if (frac == 0) begin
         hi = lo;
      end else begin
         hi = lo + 1;
         w = 65536 - frac;
      end
   endfunction

   function automatic height_result_type predict_height(sample_beat_type b);
      height_result_type r;
      int                fx, cx, fz, cz;
      longint unsigned   wx, wz, af, ac, blend, prod;
      longint            h;
      r.height = '0;
      if (b.mode == ModeWrite) begin
         grid_sum = grid_sum - grid[b.cell_x][b.cell_z] + b.cell_height;
         grid[b.cell_x][b.cell_z] = b.cell_height;
      end else begin
         map_axis(b.pos_x, cfg.origin_x, cfg.scale_x,
                  clamp_size(cfg.map_width, hbs_pkg::MaxWidth), fx, cx, wx);
         map_axis(b.pos_z, cfg.origin_z, cfg.scale_z,
                  clamp_size(cfg.map_length, hbs_pkg::MaxLength), fz, cz, wz);
         af = wx * grid[fx][fz] + (65536 - wx) * grid[cx][fz];
         ac = wx * grid[fx][cz] + (65536 - wx) * grid[cx][cz];
         blend = (wz * af + (65536 - wz) * ac) >> hbs_pkg::CellBits;
         prod = (blend * 64'(cfg.height_scale)) >> 32;
         h = longint'(prod) + longint'($signed(cfg.height_offset));
         if (h > 64'sd2147483647) h = 64'sd2147483647;
         if (h < -64'sd2147483648) h = -64'sd2147483648;
         r.height = h[31:0];
      end
      r.height_sum = grid_sum;
      return r;
   endfunction

   // Request driver: a beat is retired at the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_heights.push_back(predict_height(cur_beat));
            if (cur_beat.mode == ModeWrite) n_writes++;
            else n_queries++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_beats.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 3);
               req_if.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               cur_beat = pending_beats.pop_front();
               req_if.valid       <= 1'b1;
               req_if.mode        <= cur_beat.mode;
               req_if.cell_x      <= cur_beat.cell_x;
               req_if.cell_z      <= cur_beat.cell_z;
               req_if.cell_height <= cur_beat.cell_height;
               req_if.pos_x       <= cur_beat.pos_x;
               req_if.pos_z       <= cur_beat.pos_z;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver stalls, including one long hold-off.
   always @(posedge clock) begin
      height_result_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen++;
            if (expected_heights.size() == 0) begin
               $error("unexpected response beat: height %h sum %h",
                      rsp_if.height, rsp_if.height_sum);
               errors++;
            end else begin
               e = expected_heights.pop_front();
               if (rsp_if.height !== e.height) begin
                  $error("height: expected %h, actual %h", e.height, rsp_if.height);
                  errors++;
               end
               if (rsp_if.height_sum !== e.height_sum) begin
                  $error("height_sum: expected %h, actual %h", e.height_sum,
                         rsp_if.height_sum);
                  errors++;
               end
            end
         end
         if (!hold_done && rsp_seen >= 200) begin
            hold_done = 1'b1;
            hold_cnt = 400;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleCap) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(hbs_pkg::csr_index_type idx, bit [31:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
      case (idx)
         hbs_pkg::CSR_ORIGIN_X:      cfg.origin_x = val;
         hbs_pkg::CSR_ORIGIN_Z:      cfg.origin_z = val;
         hbs_pkg::CSR_SCALE_X:       cfg.scale_x = val;
         hbs_pkg::CSR_SCALE_Z:       cfg.scale_z = val;
         hbs_pkg::CSR_HEIGHT_SCALE:  cfg.height_scale = val;
         hbs_pkg::CSR_HEIGHT_OFFSET: cfg.height_offset = val;
         hbs_pkg::CSR_MAP_WIDTH:     cfg.map_width = val[6:0];
         hbs_pkg::CSR_MAP_LENGTH:    cfg.map_length = val[6:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || req_if.valid || expected_heights.size() > 0)
         @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic set_cfg(bit [31:0] ox, bit [31:0] oz, bit [31:0] sx, bit [31:0] sz,
                          bit [31:0] hs, bit [31:0] ho, bit [6:0] mw, bit [6:0] ml);
      drain();
      write_reg(hbs_pkg::CSR_ORIGIN_X, ox);
      write_reg(hbs_pkg::CSR_ORIGIN_Z, oz);
      write_reg(hbs_pkg::CSR_SCALE_X, sx);
      write_reg(hbs_pkg::CSR_SCALE_Z, sz);
      write_reg(hbs_pkg::CSR_HEIGHT_SCALE, hs);
      write_reg(hbs_pkg::CSR_HEIGHT_OFFSET, ho);
      write_reg(hbs_pkg::CSR_MAP_WIDTH, 32'(mw));
      write_reg(hbs_pkg::CSR_MAP_LENGTH, 32'(ml));
      n_settings++;
   endtask

   task automatic push_write(bit [5:0] x, bit [5:0] z, bit [15:0] h);
      sample_beat_type b;
      b = '{ModeWrite, x, z, h, $urandom, $urandom};
      pending_beats.push_back(b);
   endtask

   task automatic push_query(bit [31:0] px, bit [31:0] pz);
      sample_beat_type b;
      b = '{ModeQuery, 6'($urandom), 6'($urandom), 16'($urandom), px, pz};
      pending_beats.push_back(b);
   endtask

   function automatic bit [31:0] near_pos(bit [31:0] org);
      if ($urandom_range(0, 7) == 0) return $urandom;
      return org + $urandom_range(0, 70 << 16) - (32'd2 << 16);
   endfunction

   task automatic push_random(int n);
      repeat (n) begin
         if ($urandom_range(0, 9) < 4)
            push_write(6'($urandom), 6'($urandom), 16'($urandom));
         else if ($urandom_range(0, 3) == 0)
            push_query(near_pos(cfg.origin_x) & 32'hFFFF_0000,
                       near_pos(cfg.origin_z) & 32'hFFFF_0000);
         else
            push_query(near_pos(cfg.origin_x), near_pos(cfg.origin_z));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode = ModeWrite;
      req_if.cell_x = '0;
      req_if.cell_z = '0;
      req_if.cell_height = '0;
      req_if.pos_x = '0;
      req_if.pos_z = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = hbs_pkg::CSR_ORIGIN_X;
      csr_if.data = '0;
      cfg = '{32'd0, 32'd0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'd0, 7'd64, 7'd64};
      grid_sum = '0;
      foreach (grid[i, j]) grid[i][j] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_query(32'h0002_8000, 32'h0003_4000);
      push_write(6'd0, 6'd0, 16'hFFFF);
      push_write(6'd63, 6'd63, 16'hFFFF);
      push_write(6'd0, 6'd63, 16'h8001);
      push_write(6'd63, 6'd0, 16'h0001);
      push_write(6'd1, 6'd0, 16'h1234);
      push_write(6'd1, 6'd1, 16'hABCD);
      push_write(6'd0, 6'd1, 16'h5555);
      push_write(6'd0, 6'd0, 16'hC000);
      push_query(32'h8000_0000, 32'h8000_0000);
      push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_query(32'h0000_0000, 32'h0000_0000);
      push_query(32'h0000_8000, 32'h0000_8000);
      push_query(32'h0000_0001, 32'h0000_FFFF);
      push_query(32'h0001_0000, 32'h0001_0000);
      push_query(32'h003F_0000, 32'h003E_C000);
      push_query(32'hFFFF_0000, 32'h0000_4000);
      push_write(6'd63, 6'd63, 16'h0000);
      push_write(6'd40, 6'd50, 16'h7FFF);
      push_query(32'h0028_4000, 32'h0032_C000);
      push_random(280);

      set_cfg(32'hFFF0_8000, 32'h0013_3333, 32'h0000_C000, 32'h0002_0000,
              32'h0080_0000, 32'hFFFF_0000, 7'd48, 7'd20);
      push_random(250);

      set_cfg(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'h7FFF_FFFF, 7'd0, 7'd127);
      push_query(32'h8000_0000, 32'h7FFF_FFFF);
      push_random(120);

      set_cfg(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001,
              32'h0000_0000, 32'h8000_0000, 7'd1, 7'd65);
      push_random(120);

      set_cfg(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_8000,
              32'hFFFF_FFFF, 32'h8000_0000, 7'd64, 7'd64);
      push_random(120);

      set_cfg(32'h0001_0000, 32'hFFFF_8000, 32'h0001_4000, 32'h0000_E000,
              32'h0004_0000, 32'h0000_1000, 7'd33, 7'd64);
      push_random(100);
      while (pending_beats.size() > 0) @(posedge clock);
      calm = 1'b1;
      push_random(120);

      drain();
      $display("covered %0d cell writes and %0d height queries over %0d register settings",
               n_writes, n_queries, n_settings + 1);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
